/* design/fslk_pkg.sv */
// shared constants, tables and types for the fuzzy speed controller
package fslk_pkg;

    localparam int IN_W    = 16;
    localparam int SCALE_W = 7;
    localparam int SNUM_W  = 23;
    localparam int SDEN_W  = 16;
    localparam int ANUM_W  = 15;
    localparam int ADEN_W  = 9;
    localparam int OUT_W   = 7;
    localparam int ADDR_W  = 3;

    // request accepted to result strobe, in clock cycles
    localparam int PIPE_LATENCY = 18;

    localparam logic [ADDR_W-1:0] REG_CX_MIN    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_CX_MAX    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_LA_MIN    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LA_MAX    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_LEVEL_SEL = 3'd4;

    localparam logic [SCALE_W-1:0] FULL_MEMBERSHIP = 7'd100;

    localparam logic [6:0] CX_POINTS [7] = '{7'd0, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96};
    localparam logic [6:0] LA_POINTS [7] = '{7'd0, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90};

    localparam logic [6:0] LEVEL_TAB [2][7] = '{
        '{7'd70, 7'd66, 7'd62, 7'd59, 7'd56, 7'd53, 7'd50},
        '{7'd78, 7'd73, 7'd69, 7'd64, 7'd59, 7'd55, 7'd50}
    };

    localparam logic [2:0] RULE_TAB [7][7] = '{
        '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0},
        '{3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0},
        '{3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0},
        '{3'd2, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    typedef struct packed {
        logic [2:0]         seg;
        logic [SCALE_W-1:0] m0;
    } t_fuzz;

endpackage

/* design/fslk_div.sv */
// pipelined restoring divider, one quotient bit per stage
module fslk_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 16,
    parameter int Q_W   = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot
);

    localparam int W = NUM_W + Q_W;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic             r_vld [Q_W];

    genvar i;
    generate
        for (i = 0; i < Q_W; i++) begin : g_stage
            localparam int B = Q_W - 1 - i;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   q_in;
            logic             vld_in;
            logic [W-1:0]     shifted;
            logic             fits;
            logic [NUM_W-1:0] n_rem;
            logic [Q_W-1:0]   n_q;

            if (i == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign q_in   = '0;
                assign vld_in = i_valid;
            end else begin : g_next
                assign rem_in = r_rem[i-1];
                assign den_in = r_den[i-1];
                assign q_in   = r_q[i-1];
                assign vld_in = r_vld[i-1];
            end

            always_comb begin
                shifted = W'(den_in) << B;
                fits    = W'(rem_in) >= shifted;
                n_rem   = fits ? NUM_W'(W'(rem_in) - shifted) : rem_in;
                n_q     = q_in;
                n_q[B]  = fits;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[i] <= 1'b0;
                end else begin
                    r_vld[i] <= vld_in;
                end
                r_rem[i] <= n_rem;
                r_den[i] <= den_in;
                r_q[i]   <= n_q;
            end
        end
    endgenerate

    assign o_valid = r_vld[Q_W-1];
    assign o_quot  = r_q[Q_W-1];

endmodule

/* design/fuzzy_speed_from_complexity_lookahead.sv */
// top level of the two-input fuzzy speed controller
//
// Usage: raise i_start with i_complexity and i_lookahead; the request is
// taken at the clock edge where i_start is high and o_busy is low. o_busy
// stays low, so a new request can be given in every cycle.
// Each request yields one result: o_valid is high for one cycle with
// o_speed_setting, in request order. Throughput is one request per cycle;
// the path runs through two 7-stage restoring dividers in series (window
// scaling, two dividers side by side, then defuzzification) plus four
// stages for input scaling, fuzzification, rule merge and weighted sum.
// The receiver cannot stall: each result shows for exactly one cycle.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
// (0 complexity_min, 1 complexity_max, 2 lookahead_min, 3 lookahead_max,
// 4 level_table_select); write only while no request is in flight.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the
// register defaults 30, 75, 18, 37 and 0.
module fuzzy_speed_from_complexity_lookahead (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [fslk_pkg::IN_W-1:0] i_complexity,
    input  logic signed [fslk_pkg::IN_W-1:0] i_lookahead,
    input  logic                           i_cfg_we,
    input  logic [fslk_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  logic [fslk_pkg::IN_W-1:0]      i_cfg_wdata,
    output logic                           o_valid,
    output logic [fslk_pkg::OUT_W-1:0]     o_speed_setting
);

    logic signed [15:0] r_cx_min, r_cx_max, r_la_min, r_la_max;
    logic               r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx_min <= 16'sd30;
            r_cx_max <= 16'sd75;
            r_la_min <= 16'sd18;
            r_la_max <= 16'sd37;
            r_sel    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fslk_pkg::REG_CX_MIN:    r_cx_min <= i_cfg_wdata;
                fslk_pkg::REG_CX_MAX:    r_cx_max <= i_cfg_wdata;
                fslk_pkg::REG_LA_MIN:    r_la_min <= i_cfg_wdata;
                fslk_pkg::REG_LA_MAX:    r_la_max <= i_cfg_wdata;
                fslk_pkg::REG_LEVEL_SEL: r_sel    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // window clamp, offset and times 100
    function automatic logic [fslk_pkg::SNUM_W-1:0] f_num(
        input logic signed [15:0] x,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [15:0] xc;
        logic [15:0]        diff;
        xc = x;
        if (x < lo) xc = lo;
        if (x > hi) xc = hi;
        diff = 16'(17'(xc) - 17'(lo));
        if (hi <= lo) diff = '0;
        return fslk_pkg::SNUM_W'(diff) * 23'd100;
    endfunction

    function automatic logic [fslk_pkg::SDEN_W-1:0] f_den(
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        if (hi <= lo) return 16'd1;
        return 16'(17'(hi) - 17'(lo));
    endfunction

    function automatic fslk_pkg::t_fuzz f_fuzz_cx(input logic [6:0] s);
        fslk_pkg::t_fuzz r;
        logic [6:0]      d;
        logic [13:0]     p;
        r.seg = 3'd6;
        r.m0  = '0;
        for (int k = 6; k >= 1; k--) begin
            if (s <= fslk_pkg::CX_POINTS[k]) r.seg = 3'(k);
        end
        d    = fslk_pkg::CX_POINTS[r.seg] - s;
        p    = 14'(d) * 14'd100;
        r.m0 = 7'(p >> 4);
        if (s >= fslk_pkg::CX_POINTS[6]) begin
            r.seg = 3'd6;
            r.m0  = '0;
        end
        if (s == 7'd0) begin
            r.seg = 3'd1;
            r.m0  = fslk_pkg::FULL_MEMBERSHIP;
        end
        return r;
    endfunction

    function automatic fslk_pkg::t_fuzz f_fuzz_la(input logic [6:0] s);
        fslk_pkg::t_fuzz r;
        logic [6:0]      d;
        logic [9:0]      p;
        r.seg = 3'd6;
        r.m0  = '0;
        for (int k = 6; k >= 1; k--) begin
            if (s <= fslk_pkg::LA_POINTS[k]) r.seg = 3'(k);
        end
        d = fslk_pkg::LA_POINTS[r.seg] - s;
        // first segment is 40 wide, the others 10
        if (r.seg == 3'd1) p = (10'(d) * 10'd5) >> 1;
        else               p = 10'(d) * 10'd10;
        r.m0 = 7'(p);
        if (s >= fslk_pkg::LA_POINTS[6]) begin
            r.seg = 3'd6;
            r.m0  = '0;
        end
        if (s == 7'd0) begin
            r.seg = 3'd1;
            r.m0  = fslk_pkg::FULL_MEMBERSHIP;
        end
        return r;
    endfunction

    // stage 0: scaling numerators and divisors
    logic                          r_v0;
    logic [fslk_pkg::SNUM_W-1:0]   r_cx_num, r_la_num;
    logic [fslk_pkg::SDEN_W-1:0]   r_cx_den, r_la_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start && !o_busy;
        end
        r_cx_num <= f_num(i_complexity, r_cx_min, r_cx_max);
        r_la_num <= f_num(i_lookahead, r_la_min, r_la_max);
        r_cx_den <= f_den(r_cx_min, r_cx_max);
        r_la_den <= f_den(r_la_min, r_la_max);
    end

    logic                         cx_v, la_v;
    logic [fslk_pkg::SCALE_W-1:0] cx_s, la_s;

    fslk_div #(
        .NUM_W(fslk_pkg::SNUM_W), .DEN_W(fslk_pkg::SDEN_W), .Q_W(fslk_pkg::SCALE_W)
    ) u_cx_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0),
        .i_num(r_cx_num), .i_den(r_cx_den), .o_valid(cx_v), .o_quot(cx_s)
    );

    fslk_div #(
        .NUM_W(fslk_pkg::SNUM_W), .DEN_W(fslk_pkg::SDEN_W), .Q_W(fslk_pkg::SCALE_W)
    ) u_la_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0),
        .i_num(r_la_num), .i_den(r_la_den), .o_valid(la_v), .o_quot(la_s)
    );

    // stage 8: fuzzify, rule lookup, min weights
    fslk_pkg::t_fuzz fz_cx, fz_la;
    logic [2:0]      n_lab [4];
    logic [6:0]      n_w   [4];
    logic [6:0]      pm1, dm1;

    always_comb begin
        fz_cx = f_fuzz_cx(cx_s);
        fz_la = f_fuzz_la(la_s);
        pm1   = fslk_pkg::FULL_MEMBERSHIP - fz_cx.m0;
        dm1   = fslk_pkg::FULL_MEMBERSHIP - fz_la.m0;
        n_lab[0] = fslk_pkg::RULE_TAB[fz_cx.seg - 3'd1][fz_la.seg - 3'd1];
        n_lab[1] = fslk_pkg::RULE_TAB[fz_cx.seg][fz_la.seg - 3'd1];
        n_lab[2] = fslk_pkg::RULE_TAB[fz_cx.seg - 3'd1][fz_la.seg];
        n_lab[3] = fslk_pkg::RULE_TAB[fz_cx.seg][fz_la.seg];
        n_w[0]   = (fz_cx.m0 <= fz_la.m0) ? fz_cx.m0 : fz_la.m0;
        n_w[1]   = (pm1 <= fz_la.m0) ? pm1 : fz_la.m0;
        n_w[2]   = (fz_cx.m0 <= dm1) ? fz_cx.m0 : dm1;
        n_w[3]   = (pm1 <= dm1) ? pm1 : dm1;
    end

    logic       r_v8;
    logic [2:0] r_lab [4];
    logic [6:0] r_w8  [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= cx_v && la_v;
        end
        r_lab <= n_lab;
        r_w8  <= n_w;
    end

    // stage 9: merge equal labels, look up levels
    logic [6:0] dw [4];
    logic [6:0] n_lv [4];

    always_comb begin
        dw = r_w8;
        for (int i = 0; i < 4; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                if (r_lab[i] == r_lab[j]) begin
                    if (dw[i] > dw[j]) dw[j] = '0;
                    else               dw[i] = '0;
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            n_lv[i] = fslk_pkg::LEVEL_TAB[r_sel][r_lab[i]];
        end
    end

    logic       r_v9;
    logic [6:0] r_w9 [4];
    logic [6:0] r_lv [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else begin
            r_v9 <= r_v8;
        end
        r_w9 <= dw;
        r_lv <= n_lv;
    end

    // stage 10: weighted sums
    logic [fslk_pkg::ANUM_W-1:0] n_anum;
    logic [fslk_pkg::ADEN_W-1:0] n_aden;

    always_comb begin
        n_anum = '0;
        n_aden = '0;
        for (int i = 0; i < 4; i++) begin
            n_anum = n_anum + fslk_pkg::ANUM_W'(14'(r_w9[i]) * 14'(r_lv[i]));
            n_aden = n_aden + fslk_pkg::ADEN_W'(r_w9[i]);
        end
        // empty weight sum gives zero speed
        if (n_aden == '0) begin
            n_anum = '0;
            n_aden = 9'd1;
        end
    end

    logic                        r_v10;
    logic [fslk_pkg::ANUM_W-1:0] r_anum;
    logic [fslk_pkg::ADEN_W-1:0] r_aden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else begin
            r_v10 <= r_v9;
        end
        r_anum <= n_anum;
        r_aden <= n_aden;
    end

    fslk_div #(
        .NUM_W(fslk_pkg::ANUM_W), .DEN_W(fslk_pkg::ADEN_W), .Q_W(fslk_pkg::OUT_W)
    ) u_avg_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v10),
        .i_num(r_anum), .i_den(r_aden), .o_valid(o_valid), .o_quot(o_speed_setting)
    );

endmodule

/* design/fslk_checker.sv */
// port-level checks for the fuzzy speed controller
module fslk_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic                       o_valid,
    input logic [fslk_pkg::OUT_W-1:0] o_speed_setting
);

    // a result always stems from a request a fixed latency earlier
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, fslk_pkg::PIPE_LATENCY))
        else $error("result without matching request");

    // speed is a weighted average of levels between 50 and 78
    a_speed_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_speed_setting >= 7'd50)
        else $error("speed below lowest level");

    a_speed_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_speed_setting <= 7'd78)
        else $error("speed above highest level");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

endmodule

bind fuzzy_speed_from_complexity_lookahead fslk_checker u_fslk_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy(o_busy),
    .o_valid(o_valid),
    .o_speed_setting(o_speed_setting)
);

/* sim/fslk_speed_checker.sv */
// checker: predicts the speed setting of each request and compares results
module fslk_speed_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic signed [fslk_pkg::IN_W-1:0] i_complexity,
    input  logic signed [fslk_pkg::IN_W-1:0] i_lookahead,
    input  logic                             i_cfg_we,
    input  logic [fslk_pkg::ADDR_W-1:0]      i_cfg_addr,
    input  logic [fslk_pkg::IN_W-1:0]        i_cfg_wdata,
    input  logic                             i_valid,
    input  logic [fslk_pkg::OUT_W-1:0]       i_speed_setting,
    output int                               o_fail_count,
    output int                               o_pending
);
    import fslk_pkg::*;

    int cx_lo, cx_hi, la_lo, la_hi;
    bit lvl_sel;
    logic [OUT_W-1:0] speed_queue [$];

    function automatic int scale_to_pct(int x, int lo, int hi);
        int v;
        if (hi <= lo) return 0;
        v = x < lo ? lo : (x > hi ? hi : x);
        return ((v - lo) * 100) / (hi - lo);
    endfunction

    // segment number and lower membership over seven breakpoints
    function automatic void fuzz_pct(int s, bit use_la, output int seg, output int m0);
        int bp [7];
        for (int k = 0; k < 7; k++) bp[k] = use_la ? int'(LA_POINTS[k]) : int'(CX_POINTS[k]);
        seg = 6;
        m0 = 0;
        if (s == 0) begin
            seg = 1;
            m0 = 100;
        end else if (s < bp[6]) begin
            for (int k = 1; k < 7; k++) begin
                if (s <= bp[k]) begin
                    seg = k;
                    m0 = (100 * (bp[k] - s)) / (bp[k] - bp[k-1]);
                    break;
                end
            end
        end
    endfunction

    function automatic logic [OUT_W-1:0] calc_speed(int cx, int la);
        int pn, dn, p0, d0, num, den;
        int lab [4];
        int w [4];
        fuzz_pct(scale_to_pct(cx, cx_lo, cx_hi), 1'b0, pn, p0);
        fuzz_pct(scale_to_pct(la, la_lo, la_hi), 1'b1, dn, d0);
        lab[0] = RULE_TAB[pn-1][dn-1];
        lab[1] = RULE_TAB[pn][dn-1];
        lab[2] = RULE_TAB[pn-1][dn];
        lab[3] = RULE_TAB[pn][dn];
        w[0] = p0 < d0 ? p0 : d0;
        w[1] = (100 - p0) < d0 ? (100 - p0) : d0;
        w[2] = p0 < (100 - d0) ? p0 : (100 - d0);
        w[3] = (100 - p0) < (100 - d0) ? (100 - p0) : (100 - d0);
        // equal labels: keep the strictly larger weight, later one on a tie
        for (int i = 0; i < 4; i++)
            for (int j = i + 1; j < 4; j++)
                if (lab[i] == lab[j]) begin
                    if (w[i] > w[j]) w[j] = 0;
                    else w[i] = 0;
                end
        num = 0;
        den = 0;
        for (int i = 0; i < 4; i++) begin
            num += w[i] * int'(LEVEL_TAB[lvl_sel][lab[i]]);
            den += w[i];
        end
        return den != 0 ? OUT_W'(num / den) : '0;
    endfunction

    assign o_pending = speed_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            cx_lo = 30; cx_hi = 75; la_lo = 18; la_hi = 37; lvl_sel = 0;
            speed_queue.delete();
        end else begin
            if (i_valid) begin
                if (speed_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result speed=%0d", i_speed_setting);
                end else begin
                    want = speed_queue.pop_front();
                    if (want !== i_speed_setting) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("speed mismatch: expected %0d actual %0d",
                                     want, i_speed_setting);
                    end
                end
            end
            if (i_start && !i_busy)
                speed_queue.push_back(calc_speed(int'(i_complexity), int'(i_lookahead)));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_CX_MIN:    cx_lo = int'($signed(i_cfg_wdata));
                    REG_CX_MAX:    cx_hi = int'($signed(i_cfg_wdata));
                    REG_LA_MIN:    la_lo = int'($signed(i_cfg_wdata));
                    REG_LA_MAX:    la_hi = int'($signed(i_cfg_wdata));
                    REG_LEVEL_SEL: lvl_sel = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

/* sim/tb_fuzzy_speed_from_complexity_lookahead.sv */
// testbench top: drives requests and register writes, gives the verdict
module tb_fuzzy_speed_from_complexity_lookahead;
    import fslk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 0, i_rst_n = 0, i_start = 0, i_cfg_we = 0;
    logic signed [IN_W-1:0] i_complexity = '0, i_lookahead = '0;
    logic [ADDR_W-1:0] i_cfg_addr = '0;
    logic [IN_W-1:0] i_cfg_wdata = '0;
    logic o_busy, o_valid;
    logic [OUT_W-1:0] o_speed_setting;
    int fail_count, pending, cycles, gap_pct;

    always #2 i_clk = ~i_clk;

    fuzzy_speed_from_complexity_lookahead uut (.*);

    fslk_speed_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_complexity, .i_lookahead,
        .i_cfg_we, .i_cfg_addr, .i_cfg_wdata, .i_valid(o_valid), .i_speed_setting(o_speed_setting),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // start stays high between back-to-back requests, drops only on idle cycles
    task automatic send_request(logic signed [IN_W-1:0] cx, logic signed [IN_W-1:0] la);
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 0;
            @(negedge i_clk);
        end
        i_start <= 1;
        i_complexity <= cx;
        i_lookahead <= la;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        i_start <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [IN_W-1:0] data);
        i_cfg_we <= 1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    // near the window most of the time, full range now and then
    function automatic logic [IN_W-1:0] pick_value(int lo, int hi);
        int span;
        if ($urandom_range(9) == 0) return IN_W'($urandom);
        span = (hi > lo ? hi - lo : 40) + 20;
        return IN_W'(lo - 10 + int'($urandom_range(span)));
    endfunction

    task automatic run_setting(int cl, int ch, int ll, int lh, bit sel, int n);
        write_reg(REG_CX_MIN, IN_W'(cl));
        write_reg(REG_CX_MAX, IN_W'(ch));
        write_reg(REG_LA_MIN, IN_W'(ll));
        write_reg(REG_LA_MAX, IN_W'(lh));
        write_reg(REG_LEVEL_SEL, IN_W'(sel));
        for (int i = 0; i < n; i++) begin
            gap_pct = i < n / 3 ? 22 : (i < 2 * n / 3 ? 75 : 0);
            send_request(pick_value(cl, ch), pick_value(ll, lh));
        end
        drain_pipe();
    endtask

    initial begin
        cycles = 0;
        gap_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // reset defaults: window edges, just outside the window and extreme inputs
        send_request(16'sd30, 16'sd18);
        send_request(16'sd75, 16'sd37);
        send_request(16'sd29, 16'sd17);
        send_request(16'sd76, 16'sd38);
        send_request(-16'sd32768, 16'sd32767);
        send_request(16'sd32767, -16'sd32768);
        send_request(16'sd73, 16'sd35);
        send_request(16'sd52, 16'sd28);
        send_request(16'sd37, 16'sd26);
        for (int c = 30; c <= 76; c += 3) send_request(IN_W'(c), IN_W'(18 + (c % 20)));
        drain_pipe();
        write_reg(REG_LEVEL_SEL, 16'd1);
        write_reg(REG_CX_MAX, 16'd30);
        send_request(16'sd50, 16'sd30);
        send_request(-16'sd5, 16'sd22);
        drain_pipe();
        run_setting(30, 75, 18, 37, 0, 300);
        run_setting(0, 100, 0, 100, 1, 300);
        run_setting(-32768, 32767, -32768, 32767, 0, 200);
        run_setting(-200, -100, 500, 7, 1, 150);
        run_setting(-32768, -32767, 32766, 32767, 1, 150);
        run_setting(10, 2000, -1000, 1000, 0, 420);
        run_setting(5, 5, 40, 41, 1, 150);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* fuzzy_speed_from_complexity_lookahead.f */
design/fslk_pkg.sv
design/fslk_div.sv
design/fuzzy_speed_from_complexity_lookahead.sv
design/fslk_checker.sv
sim/fslk_speed_checker.sv
sim/tb_fuzzy_speed_from_complexity_lookahead.sv
